// ----- sv/nta_pkg.sv -----
// Shared types, codes and lookup functions for the number-to-ASCII formatter.
package nta_pkg;

   localparam int OpWidth    = 2;
   localparam int ValueWidth = 32;
   localparam int CharWidth  = 7;
   localparam int PosWidth   = 4;
   localparam int DigitWidth = 4;
   localparam int WideWidth  = 34;   // holds nine times the top decimal power
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = 1;
   localparam int QueueCntWidth = 2;

   // operation codes
   localparam logic [OpWidth-1:0] OP_DECIMAL  = 2'd0;
   localparam logic [OpWidth-1:0] OP_BYTE_HEX = 2'd1;
   localparam logic [OpWidth-1:0] OP_WORD_HEX = 2'd2;
   localparam logic [OpWidth-1:0] OP_UNUSED   = 2'd3;

   localparam logic [CharWidth-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CharWidth-1:0] CHAR_X    = 7'h78;
   localparam logic [CharWidth-1:0] CHAR_A    = 7'h61;

   // digit positions: 0 is the 10^9 place, 9 the units place
   localparam logic [PosWidth-1:0] DEC_LAST_POS  = 4'd9;
   localparam logic [PosWidth-1:0] WORD_LAST_POS = 4'd9;
   localparam logic [PosWidth-1:0] BYTE_LAST_POS = 4'd3;
   localparam logic [PosWidth-1:0] HEX_PREFIX_X  = 4'd1;

   typedef struct packed {
      logic [OpWidth-1:0]    op;
      logic [ValueWidth-1:0] value;
   } nta_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEC_DIG,
      ST_DEC_EMIT,
      ST_HEX_EMIT
   } nta_state_type;

   // power of ten for a digit position
   function automatic logic [WideWidth-1:0] dec_power(input logic [PosWidth-1:0] pos);
      logic [WideWidth-1:0] p;
      unique case (pos)
         4'd0:    p = 34'd1000000000;
         4'd1:    p = 34'd100000000;
         4'd2:    p = 34'd10000000;
         4'd3:    p = 34'd1000000;
         4'd4:    p = 34'd100000;
         4'd5:    p = 34'd10000;
         4'd6:    p = 34'd1000;
         4'd7:    p = 34'd100;
         4'd8:    p = 34'd10;
         default: p = 34'd1;
      endcase
      return p;
   endfunction

   // k times the power of ten at a position (constant table per k)
   function automatic logic [WideWidth-1:0] dec_multiple(input logic [PosWidth-1:0]   pos,
                                                         input logic [DigitWidth-1:0] k);
      logic [WideWidth-1:0] m;
      m = dec_power(pos) * {{(WideWidth-DigitWidth){1'b0}}, k};
      return m;
   endfunction

   function automatic logic [CharWidth-1:0] hex_glyph(input logic [3:0] nib);
      logic [CharWidth-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {3'b000, nib};
      end else begin
         c = CHAR_A + {3'b000, nib - 4'd10};
      end
      return c;
   endfunction

endpackage

// ----- sv/nta_front.sv -----
// Front end: takes request transactions, drops unused selectors, queues the rest.
module nta_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // [1:0] operation, [33:2] value, [39:34] zero
   input  logic                  q_full,
   output logic                  q_push,
   output nta_pkg::nta_item_type q_item
);
   import nta_pkg::*;

   logic accept;

   assign req_tready  = !q_full;
   assign accept      = req_tvalid && req_tready;
   assign q_item.op    = req_tdata[OpWidth-1:0];
   assign q_item.value = req_tdata[OpWidth+ValueWidth-1:OpWidth];

   // unused selector yields no characters, so it never reaches the queue
   always_comb begin
      q_push = 1'b0;
      unique case (q_item.op)
         OP_DECIMAL, OP_BYTE_HEX, OP_WORD_HEX: q_push = accept;
         OP_UNUSED:                            q_push = 1'b0;
         default:                              q_push = 1'b0;
      endcase
   end

   no_push_when_full_a: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

   no_push_unused_a: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_item.op != OP_UNUSED))
      else $error("unused selector queued");

   push_needs_accept_a: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready))
      else $error("push without accepted transaction");

endmodule

// ----- sv/nta_queue.sv -----
// Two-entry queue between front and back ends.
module nta_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nta_pkg::nta_item_type push_item,
   input  logic                  pop,
   output nta_pkg::nta_item_type pop_item,
   output logic                  full,
   output logic                  empty
);
   import nta_pkg::*;

   nta_item_type                entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   assign full     = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntWidth'(QueueDepth))
      else $error("queue count overflow");

   push_only_a: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   pop_only_a: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on pop");

endmodule

// ----- sv/nta_back.sv -----
// Back end: turns one queued number into characters and drives the response register.
module nta_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  nta_pkg::nta_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [6:0] character, [7] zero
   output logic                  rsp_tlast
);
   import nta_pkg::*;

   nta_state_type           st_ff, st_in;
   logic [ValueWidth-1:0]   x_ff, x_in;
   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic [DigitWidth-1:0]   digit_ff, digit_in;
   logic                    started_ff, started_in;
   logic                    word_ff, word_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]    rsp_char_ff;
   logic                    rsp_last_ff;

   logic                    out_free;
   logic                    emit;
   logic [CharWidth-1:0]    emit_char;
   logic                    emit_last;
   logic                    show;
   logic [DigitWidth-1:0]   dig_count;
   logic [PosWidth-1:0]     nib_idx;
   logic [PosWidth-1:0]     hex_last;
   logic [WideWidth-1:0]    remainder;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // digit value: how many multiples of the place's power fit in x
   always_comb begin
      dig_count = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({2'b00, x_ff} >= dec_multiple(pos_ff, DigitWidth'(k))) begin
            dig_count = dig_count + 1'b1;
         end
      end
   end

   assign remainder = {2'b00, x_ff} - dec_multiple(pos_ff, digit_ff);
   assign show      = (digit_ff != '0) || started_ff || (pos_ff == DEC_LAST_POS);
   assign hex_last  = word_ff ? WORD_LAST_POS : BYTE_LAST_POS;
   assign nib_idx   = hex_last - pos_ff;

   always_comb begin
      st_in      = st_ff;
      x_in       = x_ff;
      pos_in     = pos_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      word_in    = word_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      emit_char  = CHAR_ZERO;
      emit_last  = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               x_in       = q_item.value;
               pos_in     = '0;
               started_in = 1'b0;
               word_in    = (q_item.op == OP_WORD_HEX);
               st_in      = (q_item.op == OP_DECIMAL) ? ST_DEC_DIG : ST_HEX_EMIT;
            end
         end
         ST_DEC_DIG: begin
            digit_in = dig_count;
            st_in    = ST_DEC_EMIT;
         end
         ST_DEC_EMIT: begin
            emit_char = CHAR_ZERO + {3'b000, digit_ff};
            emit_last = (pos_ff == DEC_LAST_POS);
            if (!show || out_free) begin
               emit       = show;
               x_in       = remainder[ValueWidth-1:0];
               started_in = started_ff || show;
               if (pos_ff == DEC_LAST_POS) begin
                  st_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  st_in  = ST_DEC_DIG;
               end
            end
         end
         ST_HEX_EMIT: begin
            if (pos_ff == '0) begin
               emit_char = CHAR_ZERO;
            end else if (pos_ff == HEX_PREFIX_X) begin
               emit_char = CHAR_X;
            end else begin
               emit_char = hex_glyph(x_ff[{nib_idx[2:0], 2'b00} +: 4]);
            end
            emit_last = (pos_ff == hex_last);
            if (out_free) begin
               emit = 1'b1;
               if (pos_ff == hex_last) begin
                  st_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      pos_ff     <= pos_in;
      digit_ff   <= digit_in;
      started_ff <= started_in;
      word_ff    <= word_in;
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   digit_range_a: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DEC_EMIT) |-> (digit_ff <= 4'd9))
      else $error("decimal digit out of range");

   hex_pos_range_a: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_HEX_EMIT) |-> (pos_ff <= hex_last))
      else $error("hex character index past end");

   last_ends_item_a: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (st_ff == ST_IDLE))
      else $error("sequencer busy after last character");

   no_overwrite_a: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("response register overwritten while stalled");

endmodule

// ----- sv/number_to_ascii_formatter.sv -----
// Top level of the number-to-ASCII formatter: front end, queue and back end.
//
// Usage: a request transaction carries a 2-bit operation and a 32-bit value;
// the block answers with a run of ASCII characters, one per response
// transaction, tlast set on the final one. Operation 0 gives decimal digits
// with leading zeros suppressed (a lone '0' for zero), 1 gives "0x" and two
// lower-case hex digits of the low byte, 2 gives "0x" and eight hex digits.
// Operation 3 is accepted and dropped without any response.
// Sequence: hex forms pop the item, then send; decimal pops, then handles
// each place with a digit compare and then a subtract and send, so a
// leading zero place is still walked but sends nothing.
// Throughput: hex forms send one character per cycle while the receiver
// is ready; decimal walks all ten places (digit compare, then subtract and
// send). The back-end sequencer sets the rate; a two-entry queue lets the
// front end keep taking requests while a number is being printed.
// Reset: synchronous, active high; clears the queue, sequencer and the
// response valid. Receiver stall: the response register holds its
// character, the sequencer waits, and once the queue fills req_tready drops.
module number_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] operation, [33:2] value, [39:34] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] character, [7] zero
   output logic        rsp_tlast
);
   import nta_pkg::*;

   nta_item_type push_item;
   nta_item_type pop_item;
   logic         q_push, q_pop, q_full, q_empty;

   // classify and queue incoming transactions
   nta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   nta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // character sequencer with registered response
   nta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
